[rtl/ricache_pkg.sv]
// Shared types and codes for the refcounted inode slot cache.
// No dependencies; used by refcounted_inode_slot_cache_core, the checker and tb_top.
package ricache_pkg;

  localparam int DevW    = 8;
  localparam int InoW    = 24;
  localparam int CountW  = 8;
  localparam int SlotW   = 6;
  localparam int BlockW  = 32;
  localparam int OffW    = 3;
  localparam int StatusW = 3;

  // inodes held by one on-disk block; must be a power of two
  localparam int InodesPerBlock = 8;
  localparam int BlockShift     = $clog2(InodesPerBlock);
  localparam logic [OffW-1:0] OffMask = OffW'(InodesPerBlock - 1);

  // operation codes on the input beat
  localparam logic [1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_DIRTY   = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STAT_HIT    = 3'd0;
  localparam logic [StatusW-1:0] STAT_LOAD   = 3'd1;
  localparam logic [StatusW-1:0] STAT_FULL   = 3'd2;
  localparam logic [StatusW-1:0] STAT_HELD   = 3'd3;
  localparam logic [StatusW-1:0] STAT_CLEAN  = 3'd4;
  localparam logic [StatusW-1:0] STAT_WBACK  = 3'd5;
  localparam logic [StatusW-1:0] STAT_MARKED = 3'd6;

  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

  // one slot of the table as stored in the slot memory
  typedef struct packed {
    logic [DevW-1:0]   dev;
    logic [InoW-1:0]   ino;
    logic [CountW-1:0] cnt;
    logic              dirty;
  } slot_entry_t;

endpackage

[rtl/refcounted_inode_slot_cache_core.sv]
// Refcounted inode slot cache: slot memory, scan sequencer and block locator.
// Depends on ricache_pkg.
//
// Channel  Dir  Signals                      Payload (low bit up)
// s        in   s_tvalid_i/s_tready_o        s_tdata_i: mode, dev, ino, slot
// m        out  m_tvalid_o/m_tready_i        m_tdata_o: status, bad_release, slot_out,
//                                            dev_out, block_out, offset_out
// cfg      in   cfg_we_i                     cfg_wdata_i: inode_table_start
//
// Acquire: scan, scan end and decide, plus a block add when a load is reported;
// the scan reads one slot per cycle from the single-port slot memory. Release and
// mark dirty: slot read and update, plus a block add for a write-back. In the
// block add, block and offset come from a shift and a mask of the inode index. One
// item at a time; s_tready_o is high only while idle. A result waits in the output
// register, and a new beat is taken meanwhile; that item then holds in its last
// step until the register drains. Reset clears the per-slot valid bits at once, so
// no clearing pass is needed.
module refcounted_inode_slot_cache_core #(
  parameter int SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // mode[1:0], dev[9:2], ino[33:10], slot[39:34]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o,   // status[2:0], bad_release[3], slot_out[9:4],
                                   // dev_out[17:10], block_out[49:18],
                                   // offset_out[52:50], zero[55:53]
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [8:0]    SlotsW   = 9'(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SCEND  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // ---------------------------------------------------------------- input unpack
  logic [1:0]  in_mode;
  logic [7:0]  in_dev;
  logic [23:0] in_ino;
  logic [5:0]  in_slot;
  logic [8:0]  in_slot_ext;
  logic        in_slot_ok;

  assign in_mode     = s_tdata_i[1:0];
  assign in_dev      = s_tdata_i[9:2];
  assign in_ino      = s_tdata_i[33:10];
  assign in_slot     = s_tdata_i[39:34];
  assign in_slot_ext = {3'b000, in_slot};
  assign in_slot_ok  = (in_slot_ext < SlotsW);

  // ---------------------------------------------------------------- registers
  logic [2:0]      state_q, state_d;
  logic [31:0]     table_start_q;
  logic [1:0]      mode_q;
  logic [7:0]      dev_q;
  logic [23:0]     ino_q;
  logic [IdxW-1:0] slot_idx_q;
  logic [IdxW-1:0] addr_q, addr_d;
  logic [IdxW-1:0] rd_idx_q;
  logic            cmp_vld_q;
  logic            hit_found_q, hit_found_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [7:0]      hit_cnt_q, hit_cnt_d;
  logic            hit_dirty_q, hit_dirty_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [23:0]     ino_idx_q, ino_idx_d;

  logic [2:0]      res_status_q, res_status_d;
  logic            res_bad_q, res_bad_d;
  logic [5:0]      res_slot_q, res_slot_d;
  logic [7:0]      res_dev_q, res_dev_d;
  logic [31:0]     res_block_q, res_block_d;
  logic [2:0]      res_off_q, res_off_d;

  logic            out_vld_q;
  logic [55:0]     out_data_q;
  logic            out_load;

  // ---------------------------------------------------------------- slot memory
  ricache_pkg::slot_entry_t mem_q [SLOTS];
  logic [SLOTS-1:0]         vld_q;
  ricache_pkg::slot_entry_t rd_data_q;
  logic                     rd_vld_q;
  ricache_pkg::slot_entry_t ent;

  logic                     rd_en;
  logic [IdxW-1:0]          rd_addr;
  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  ricache_pkg::slot_entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // a slot never written reads as all zero
  assign ent = rd_vld_q ? rd_data_q : '0;

  // ---------------------------------------------------------------- sequencer
  logic [7:0] cnt_dec;
  logic [7:0] cnt_inc;

  assign cnt_dec = ent.cnt - 8'd1;
  assign cnt_inc = (hit_cnt_q == ricache_pkg::COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 8'd1;

  assign s_tready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_vld_q || m_tready_i);

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_cnt_d    = hit_cnt_q;
    hit_dirty_d  = hit_dirty_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    ino_idx_d    = ino_idx_q;
    res_status_d = res_status_q;
    res_bad_d    = res_bad_q;
    res_slot_d   = res_slot_q;
    res_dev_d    = res_dev_q;
    res_block_d  = res_block_q;
    res_off_d    = res_off_q;
    rd_en        = 1'b0;
    rd_addr      = addr_q;
    wr_en        = 1'b0;
    wr_addr      = slot_idx_q;
    wr_data      = ent;

    // scan compare on the slot read in the previous cycle
    if (cmp_vld_q) begin
      if (!hit_found_q && ent.dev == dev_q && ent.ino == ino_q) begin
        hit_found_d = 1'b1;
        hit_idx_d   = rd_idx_q;
        hit_cnt_d   = ent.cnt;
        hit_dirty_d = ent.dirty;
      end
      if (!free_found_q && ent.cnt == '0) begin
        free_found_d = 1'b1;
        free_idx_d   = rd_idx_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          res_status_d = ricache_pkg::STAT_MARKED;
          res_bad_d    = 1'b0;
          res_slot_d   = in_slot;
          res_dev_d    = '0;
          res_block_d  = '0;
          res_off_d    = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          addr_d       = '0;
          if (in_mode == ricache_pkg::MODE_ACQUIRE) begin
            state_d = S_SCAN;
          end else if ((in_mode == ricache_pkg::MODE_RELEASE ||
                        in_mode == ricache_pkg::MODE_DIRTY) && in_slot_ok) begin
            rd_en   = 1'b1;
            rd_addr = in_slot_ext[IdxW-1:0];
            state_d = S_UPDATE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = addr_q;
        addr_d  = addr_q + IdxW'(1);
        if (addr_q == LastIdx) begin
          state_d = S_SCEND;
        end
      end
      S_SCEND: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (hit_found_q) begin
          wr_en        = 1'b1;
          wr_addr      = hit_idx_q;
          wr_data      = '{dev: dev_q, ino: ino_q, cnt: cnt_inc, dirty: hit_dirty_q};
          res_status_d = ricache_pkg::STAT_HIT;
          res_slot_d   = 6'(hit_idx_q);
          state_d      = S_OUT;
        end else if (free_found_q) begin
          wr_en        = 1'b1;
          wr_addr      = free_idx_q;
          wr_data      = '{dev: dev_q, ino: ino_q, cnt: 8'd1, dirty: 1'b0};
          res_status_d = ricache_pkg::STAT_LOAD;
          res_slot_d   = 6'(free_idx_q);
          res_dev_d    = dev_q;
          ino_idx_d    = ino_q - 24'd1;
          state_d      = S_ADD;
        end else begin
          res_status_d = ricache_pkg::STAT_FULL;
          res_slot_d   = '0;
          state_d      = S_OUT;
        end
      end
      S_UPDATE: begin
        state_d = S_OUT;
        wr_addr = slot_idx_q;
        if (mode_q == ricache_pkg::MODE_DIRTY) begin
          wr_en         = 1'b1;
          wr_data       = ent;
          wr_data.dirty = 1'b1;
        end else if (ent.cnt == '0) begin
          res_bad_d = 1'b1;
        end else begin
          wr_en       = 1'b1;
          wr_data     = ent;
          wr_data.cnt = cnt_dec;
          if (cnt_dec != '0) begin
            res_status_d = ricache_pkg::STAT_HELD;
          end else if (ent.dirty) begin
            // report the write-back and clear the dirty mark
            wr_data.dirty = 1'b0;
            res_status_d  = ricache_pkg::STAT_WBACK;
            res_dev_d     = ent.dev;
            ino_idx_d     = ent.ino - 24'd1;
            state_d       = S_ADD;
          end else begin
            res_status_d = ricache_pkg::STAT_CLEAN;
          end
        end
      end
      S_ADD: begin
        // block size is a power of two: shift for the block, mask for the offset
        res_block_d = {8'h00, ino_idx_q >> ricache_pkg::BlockShift} + table_start_q;
        res_off_d   = ino_idx_q[2:0] & ricache_pkg::OffMask;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      table_start_q <= '0;
      cmp_vld_q     <= 1'b0;
      hit_found_q   <= 1'b0;
      free_found_q  <= 1'b0;
      out_vld_q     <= 1'b0;
      addr_q        <= '0;
    end else begin
      state_q      <= state_d;
      cmp_vld_q    <= (state_q == S_SCAN);
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      addr_q       <= addr_d;
      if (cfg_we_i) begin
        table_start_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      mode_q     <= in_mode;
      dev_q      <= in_dev;
      ino_q      <= in_ino;
      slot_idx_q <= in_slot_ext[IdxW-1:0];
    end
    rd_idx_q     <= addr_q;
    hit_idx_q    <= hit_idx_d;
    hit_cnt_q    <= hit_cnt_d;
    hit_dirty_q  <= hit_dirty_d;
    free_idx_q   <= free_idx_d;
    ino_idx_q    <= ino_idx_d;
    res_status_q <= res_status_d;
    res_bad_q    <= res_bad_d;
    res_slot_q   <= res_slot_d;
    res_dev_q    <= res_dev_d;
    res_block_q  <= res_block_d;
    res_off_q    <= res_off_d;
    if (out_load) begin
      out_data_q <= {3'b000, res_off_q, res_block_q, res_dev_q, res_slot_q,
                     res_bad_q, res_status_q};
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

`ifndef ASSERT_OFF
  // a flagged release always carries the marked status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[3] |-> m_tdata_o[2:0] == ricache_pkg::STAT_MARKED)
    else $error("bad_release without marked status");

  // no free slot reports neither a slot nor a load address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[2:0] == ricache_pkg::STAT_FULL |->
      m_tdata_o[9:4] == '0 && m_tdata_o[49:10] == '0)
    else $error("no free slot result carries payload");

  // one item in flight: an accepted beat closes the input until done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input accepted while busy");

  // the slot memory is written only by the decide and update steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_DECIDE || state_q == S_UPDATE)
    else $error("slot memory written outside an update");
`endif

endmodule

[bench/refcounted_inode_slot_cache_checker.sv]
// Scoreboard for the inode slot cache: watches the input, result and config channels,
// keeps its own copy of the slot table and compares every result beat field by field.
// Depends on ricache_pkg.
module refcounted_inode_slot_cache_checker
  import ricache_pkg::*;
#(
  parameter int SLOTS            = 64,
  parameter int INODES_PER_BLOCK = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [InoW-1:0]  ino;
    logic [DevW-1:0]  dev;
    logic [1:0]       mode;
  } access_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic [OffW-1:0]    offset;
    logic [BlockW-1:0]  block;
    logic [DevW-1:0]    dev;
    logic [SlotW-1:0]   slot;
    logic               bad;
    logic [StatusW-1:0] status;
  } outcome_t;

  logic [DevW-1:0]   tag_dev   [SLOTS];
  logic [InoW-1:0]   tag_ino   [SLOTS];
  logic [CountW-1:0] ref_cnt   [SLOTS];
  logic              dirty     [SLOTS];
  logic [31:0]       table_start;
  outcome_t          outcomes_due[$];

  // inode numbers count from one; the index wraps within 24 bits
  function automatic logic [BlockW+OffW-1:0] locate_inode(input logic [InoW-1:0] ino);
    logic [InoW-1:0]   idx;
    logic [BlockW-1:0] blk;
    logic [OffW-1:0]   ofs;
    idx = ino - 1'b1;
    blk = BlockW'(idx / INODES_PER_BLOCK) + table_start;
    ofs = OffW'(idx % INODES_PER_BLOCK);
    return {blk, ofs};
  endfunction

  function automatic outcome_t predict_outcome(input access_t acc);
    outcome_t r;
    int       hit;
    int       vacant;
    r = '0;
    r.status = STAT_MARKED;
    r.slot = acc.slot;
    hit = -1;
    vacant = -1;
    case (acc.mode)
      MODE_ACQUIRE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && tag_dev[i] == acc.dev && tag_ino[i] == acc.ino) hit = i;
          if (vacant < 0 && ref_cnt[i] == '0) vacant = i;
        end
        if (hit >= 0) begin
          if (ref_cnt[hit] != COUNT_MAX) ref_cnt[hit]++;
          r.status = STAT_HIT;
          r.slot = SlotW'(hit);
        end else if (vacant >= 0) begin
          tag_dev[vacant] = acc.dev;
          tag_ino[vacant] = acc.ino;
          ref_cnt[vacant] = 8'd1;
          dirty[vacant] = 1'b0;
          r.status = STAT_LOAD;
          r.slot = SlotW'(vacant);
          r.dev = acc.dev;
          {r.block, r.offset} = locate_inode(acc.ino);
        end else begin
          r.status = STAT_FULL;
          r.slot = '0;
        end
      end
      MODE_RELEASE: begin
        if (acc.slot < SLOTS) begin
          if (ref_cnt[acc.slot] == '0) begin
            r.bad = 1'b1;
          end else begin
            ref_cnt[acc.slot]--;
            if (ref_cnt[acc.slot] != '0) begin
              r.status = STAT_HELD;
            end else if (dirty[acc.slot]) begin
              r.status = STAT_WBACK;
              r.dev = tag_dev[acc.slot];
              {r.block, r.offset} = locate_inode(tag_ino[acc.slot]);
              dirty[acc.slot] = 1'b0;
            end else begin
              r.status = STAT_CLEAN;
            end
          end
        end
      end
      MODE_DIRTY: begin
        if (acc.slot < SLOTS) dirty[acc.slot] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      table_start = '0;
      for (int i = 0; i < SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_ino[i] = '0;
        ref_cnt[i] = '0;
        dirty[i] = 1'b0;
      end
      outcomes_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) table_start = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (outcomes_due.size() == 0) begin
          $display("%0t: result beat expected none got %0h", $time, m_tdata_i);
          fail_count_o++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", want.status, got.status);
          check_field("bad_release", want.bad, got.bad);
          check_field("slot_out", want.slot, got.slot);
          check_field("dev_out", want.dev, got.dev);
          check_field("block_out", want.block, got.block);
          check_field("offset_out", want.offset, got.offset);
          check_field("pad", want.pad, got.pad);
        end
      end
      if (s_tvalid_i && s_tready_i) outcomes_due.push_back(predict_outcome(access_t'(s_tdata_i)));
      pending_o = outcomes_due.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Top of the inode slot cache bench: clock, reset, beat stimulus and result back-pressure.
// Depends on ricache_pkg, refcounted_inode_slot_cache_core and
// refcounted_inode_slot_cache_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ricache_pkg::*;

  localparam int         CycleLimit  = 1_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata     = '0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we      = 1'b0;
  logic [31:0] cfg_wdata   = '0;
  int          fail_count;
  int          pending;
  bit          jitter_on   = 1'b1;
  int unsigned cycles      = 0;

  logic [DevW-1:0] pool_dev [16];
  logic [InoW-1:0] pool_ino [16];

  always #1 clk = ~clk;

  refcounted_inode_slot_cache_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  refcounted_inode_slot_cache_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!jitter_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_op(input logic [1:0] mode, input logic [DevW-1:0] dev,
                         input logic [InoW-1:0] ino, input logic [SlotW-1:0] slot);
    int unsigned hold;
    hold = pick_gap();
    if (hold > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (hold - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata <= {slot, ino, dev, mode};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // write only once every outstanding result has drained
  task automatic set_table_start(input logic [31:0] value);
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 16; i++) begin
      pool_dev[i] = 8'($urandom_range(0, 255));
      pool_ino[i] = (i == 0) ? '0 : 24'($urandom_range(1, 24'hFFFFFF));
    end
  endtask

  // well-formed traffic on a small tag pool, with some noise mixed in
  task automatic mixed_op();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 15);
    if (r < 45)
      send_op(MODE_ACQUIRE, pool_dev[k], pool_ino[k], 6'($urandom()));
    else if (r < 75)
      send_op(MODE_RELEASE, 8'($urandom()), 24'($urandom()), 6'($urandom_range(0, 23)));
    else if (r < 88)
      send_op(MODE_DIRTY, 8'($urandom()), 24'($urandom()), 6'($urandom_range(0, 23)));
    else if (r < 94)
      send_op(MODE_ACQUIRE, 8'($urandom()), 24'($urandom()), 6'($urandom()));
    else if (r < 97)
      send_op(2'($urandom_range(1, 2)), 8'($urandom()), 24'($urandom()), 6'($urandom()));
    else
      send_op(MODE_UNUSED, 8'($urandom()), 24'($urandom()), 6'($urandom()));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("refcounted_inode_slot_cache_core: mismatch");
      $finish;
    end
  end

  initial begin : reset_gen
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (jitter_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [DevW-1:0] hot_dev;
    logic [InoW-1:0] hot_ino;
    @(posedge rst_n);

    // block number wraps past the top of the 32-bit range
    set_table_start(32'hFFFF_FFFF);
    send_op(MODE_ACQUIRE, 8'h00, 24'h000000, 6'h00);  // hits the all-zero reset tag
    send_op(MODE_ACQUIRE, 8'hFF, 24'hFFFFFF, 6'h3F);
    send_op(MODE_ACQUIRE, 8'h00, 24'h000001, 6'h00);
    send_op(MODE_ACQUIRE, 8'h5A, 24'h000000, 6'h15);  // index wraps to all ones
    send_op(MODE_DIRTY,   8'h00, 24'h000000, 6'h02);
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h02);  // write-back
    send_op(MODE_RELEASE, 8'hFF, 24'hFFFFFF, 6'h02);  // count already zero
    send_op(MODE_ACQUIRE, 8'h00, 24'h000001, 6'h00);  // idle slot hit
    send_op(MODE_DIRTY,   8'h00, 24'h000000, 6'h3F);  // mark an idle slot
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h3F);
    send_op(MODE_ACQUIRE, 8'hA5, 24'h123456, 6'h00);
    send_op(MODE_DIRTY,   8'h00, 24'h000000, 6'h04);
    send_op(MODE_ACQUIRE, 8'hA5, 24'h123456, 6'h00);
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h04);
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h04);
    send_op(MODE_UNUSED,  8'hFF, 24'hFFFFFF, 6'h2A);
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h01);
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h00);
    send_op(MODE_RELEASE, 8'h00, 24'h000000, 6'h03);
    send_op(MODE_ACQUIRE, 8'h00, 24'h000000, 6'h00);

    set_table_start(32'h0000_0000);
    refresh_pool();
    repeat (150) mixed_op();

    // fill the table with fresh tags until acquires find no free slot
    set_table_start($urandom());
    jitter_on = 1'b0;
    repeat (72) send_op(MODE_ACQUIRE, 8'($urandom()), 24'($urandom_range(1, 24'hFFFFFF)),
                        6'($urandom()));
    jitter_on = 1'b1;
    for (int s = 0; s < 64; s++) begin
      if ($urandom_range(0, 1) == 1) send_op(MODE_DIRTY, 8'($urandom()), 24'($urandom()), 6'(s));
      repeat (2) send_op(MODE_RELEASE, 8'($urandom()), 24'($urandom()), 6'(s));
    end

    // drive one tag past the count ceiling
    set_table_start(32'hFFFF_FFF0);
    hot_dev = 8'h3C;
    hot_ino = 24'($urandom_range(1, 24'hFFFFFF));
    repeat (258) send_op(MODE_ACQUIRE, hot_dev, hot_ino, 6'($urandom()));
    repeat (3) send_op(MODE_RELEASE, 8'($urandom()), 24'($urandom()), 6'h00);

    set_table_start($urandom());
    refresh_pool();
    repeat (60) mixed_op();

    @(negedge clk) s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (fail_count == 0)
      $display("refcounted_inode_slot_cache_core: match");
    else
      $display("refcounted_inode_slot_cache_core: mismatch");
    $finish;
  end

endmodule
